@@ hdl/spr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the shortest path edge relaxer.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int NUM_VERTICES = 4096;
    localparam int ADDR_W       = 12;
    localparam int DIST_W       = 31;

    localparam logic [DIST_W-1:0] PLUS_INF = 31'h7f80_0000;

    typedef enum logic [1:0] {
        K_SET_ZERO = 2'd0,
        K_RELAX    = 2'd1,
        K_READ     = 2'd2,
        K_END_ROUND = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] from_vertex;
        logic [ADDR_W-1:0] to_vertex;
        logic [31:0]       weight_bits;
        logic              edge_admitted;
    } t_in;

    typedef struct packed {
        logic              decreased;
        logic [DIST_W-1:0] distance_value;
        logic              round_changed;
        logic              bad_weight;
    } t_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_TO,
        S_RD_FROM,
        S_ALIGN,
        S_ROUND,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load_item;
        logic rd_from;
        logic cap_cur;
        logic cap_align;
        logic cap_sum;
        logic clr_we;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       clr_last;
        logic       out_free;
    } t_status;

endpackage
`default_nettype wire

@@ hdl/spr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ hdl/spr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer that steps one item at a time through the datapath.
// ----------------------------------------------------------------------------
module spr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire spr_pkg::t_status i_status,
    output spr_pkg::t_cmd         o_cmd,
    output logic                  o_in_stall
);

    spr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spr_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            spr_pkg::S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_status.clr_last) begin
                    n_state = spr_pkg::S_IDLE;
                end
            end
            spr_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = spr_pkg::S_RD_TO;
                end
            end
            spr_pkg::S_RD_TO: begin
                if (i_status.kind inside {spr_pkg::K_SET_ZERO, spr_pkg::K_END_ROUND}) begin
                    n_state = spr_pkg::S_FINISH;
                end else begin
                    n_state = spr_pkg::S_RD_FROM;
                end
            end
            spr_pkg::S_RD_FROM: begin
                o_cmd.cap_cur = 1'b1;
                o_cmd.rd_from = 1'b1;
                if (i_status.kind == spr_pkg::K_RELAX) begin
                    n_state = spr_pkg::S_ALIGN;
                end else begin
                    n_state = spr_pkg::S_FINISH;
                end
            end
            spr_pkg::S_ALIGN: begin
                o_cmd.cap_align = 1'b1;
                n_state = spr_pkg::S_ROUND;
            end
            spr_pkg::S_ROUND: begin
                o_cmd.cap_sum = 1'b1;
                n_state = spr_pkg::S_FINISH;
            end
            spr_pkg::S_FINISH: begin
                // Hold here until the output register can take the result.
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = spr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spr_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/spr_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spr_datapath
// Distance store, two-step float adder, compare and result register.
// ----------------------------------------------------------------------------
module spr_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire spr_pkg::t_cmd    i_cmd,
    input  wire spr_pkg::t_in     i_in_data,
    input  wire logic             i_out_stall,
    output spr_pkg::t_status      o_status,
    output logic                  o_out_valid,
    output spr_pkg::t_out         o_out_data
);

    spr_pkg::t_in                  r_item;
    logic [spr_pkg::DIST_W-1:0]    r_cur;
    logic [spr_pkg::DIST_W-1:0]    r_cand;
    logic [spr_pkg::ADDR_W-1:0]    r_clr_cnt;
    logic                          r_changed;
    logic                          r_out_valid;
    spr_pkg::t_out                 r_out;

    // Alignment stage registers.
    logic                          r_inf;
    logic                          r_sub;
    logic [spr_pkg::DIST_W-1:0]    r_direct;
    logic [7:0]                    r_exp;
    logic [26:0]                   r_mb;
    logic [26:0]                   r_ms;

    logic [spr_pkg::DIST_W-1:0]    rdata;
    logic                          we;
    logic [spr_pkg::ADDR_W-1:0]    waddr;
    logic [spr_pkg::DIST_W-1:0]    wdata;
    logic [spr_pkg::ADDR_W-1:0]    raddr;

    logic                          bad_w;
    logic                          dec;
    logic                          out_free;
    spr_pkg::t_out                 res;

    logic [spr_pkg::DIST_W-1:0]    wt, big, sml;
    logic [7:0]                    eb, es, d;
    logic [26:0]                   ext, shifted, lost_mask;
    logic                          sticky;

    logic [27:0]                   sum;
    logic [26:0]                   v;
    logic [8:0]                    e_n;
    logic                          rnd_up;
    logic [31:0]                   packed_r;

    assign raddr = i_cmd.rd_from ? r_item.from_vertex : r_item.to_vertex;

    spr_ram #(
        .WIDTH(spr_pkg::DIST_W),
        .DEPTH(spr_pkg::NUM_VERTICES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign bad_w = r_item.weight_bits[31]
        || (r_item.weight_bits[30:23] == 8'hff);
    assign dec = !bad_w && r_item.edge_admitted && (r_cand < r_cur);
    assign out_free = !r_out_valid || !i_out_stall;

    // Align: both operands are non-negative, so the sum never cancels.
    always_comb begin
        wt  = r_item.weight_bits[30:0];
        big = (rdata >= wt) ? rdata : wt;
        sml = (rdata >= wt) ? wt : rdata;
        eb  = big[30:23];
        es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d   = eb - es;
        ext = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
        if (d >= 8'd27) begin
            shifted   = 27'd0;
            lost_mask = '1;
        end else begin
            shifted   = ext >> d;
            lost_mask = ~(27'h7ff_ffff << d);
        end
        sticky = |(ext & lost_mask);
    end

    // Normalize by at most one place, then round to nearest even.
    always_comb begin
        sum = {1'b0, r_mb} + {1'b0, r_ms};
        if (sum[27]) begin
            v   = {sum[27:2], sum[1] | sum[0]};
            e_n = {1'b0, r_exp} + 9'd1;
        end else begin
            v   = sum[26:0];
            e_n = {1'b0, r_exp};
        end
        rnd_up   = v[2] & (v[1] | v[0] | v[3]);
        packed_r = {e_n, v[25:3]} + {31'd0, rnd_up};
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_item.to_vertex;
        wdata = r_cand;
        res   = '0;
        if (i_cmd.clr_we) begin
            we    = 1'b1;
            waddr = r_clr_cnt;
            wdata = spr_pkg::PLUS_INF;
        end else if (i_cmd.finish) begin
            case (r_item.kind)
                spr_pkg::K_SET_ZERO: begin
                    we    = 1'b1;
                    wdata = '0;
                end
                spr_pkg::K_RELAX: begin
                    we                 = dec;
                    res.decreased      = dec;
                    res.bad_weight     = bad_w;
                    res.distance_value = dec ? r_cand : r_cur;
                end
                spr_pkg::K_READ: begin
                    res.distance_value = r_cur;
                end
                default: begin
                    res.round_changed = r_changed;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_we) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_item.kind == spr_pkg::K_END_ROUND) begin
                    r_changed <= 1'b0;
                end else if (r_item.kind == spr_pkg::K_RELAX && dec) begin
                    r_changed <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.cap_cur) begin
            r_cur <= rdata;
        end
        if (i_cmd.cap_align) begin
            r_inf    <= (eb == 8'hff);
            r_sub    <= (eb == 8'd0);
            r_direct <= big + sml;
            r_exp    <= eb;
            r_mb     <= {1'b1, big[22:0], 3'b000};
            r_ms     <= {shifted[26:1], shifted[0] | sticky};
        end
        if (i_cmd.cap_sum) begin
            if (r_inf) begin
                r_cand <= spr_pkg::PLUS_INF;
            end else if (r_sub) begin
                // Two subnormals add as plain integers, carrying into the exponent.
                r_cand <= r_direct;
            end else if (packed_r >= {1'b0, spr_pkg::PLUS_INF}) begin
                r_cand <= spr_pkg::PLUS_INF;
            end else begin
                r_cand <= packed_r[30:0];
            end
        end
        if (i_cmd.finish) begin
            r_out <= res;
        end
    end

    assign o_status.kind     = r_item.kind;
    assign o_status.clr_last = (r_clr_cnt == spr_pkg::ADDR_W'(spr_pkg::NUM_VERTICES - 1));
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule
`default_nettype wire

@@ hdl/shortest_path_edge_relaxer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_path_edge_relaxer
// Bellman-Ford edge relaxation over a store of IEEE single distances.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      i_in_valid / o_in_stall  spr_pkg::t_in
//  out      output     o_out_valid / i_out_stall spr_pkg::t_out
//
// A relax item passes through two store reads on the single read port, two
// adder steps, a compare and write, and a return to idle; the block takes no
// new item until it is done. A read does the store reads and finishes; set
// to zero and end round go straight to finish. After reset the store is swept
// to +infinity with o_in_stall high. A stalled result holds the sequencer in
// its last step until the output register is free.
// ----------------------------------------------------------------------------
module shortest_path_edge_relaxer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire spr_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output spr_pkg::t_out      o_out_data
);

    spr_pkg::t_cmd    cmd;
    spr_pkg::t_status status;

    spr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    spr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_out_stall(i_out_stall),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

@@ test/shortest_path_edge_relaxer_checker.sv @@
// ----------------------------------------------------------------------------
// shortest_path_edge_relaxer_checker
// Watches both channels of the edge relaxer, keeps its own copy of the
// distance store and the round flag, predicts each result and compares it.
// ----------------------------------------------------------------------------
module shortest_path_edge_relaxer_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_stall,
    input  wire spr_pkg::t_in  i_in_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  wire spr_pkg::t_out i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int QDEPTH = 16;

    logic [spr_pkg::DIST_W-1:0] dist_mem [spr_pkg::NUM_VERTICES];
    logic                       round_flag;
    spr_pkg::t_out              exp_q [QDEPTH];
    logic [$clog2(QDEPTH)-1:0]  q_wr;
    logic [$clog2(QDEPTH)-1:0]  q_rd;
    int                         q_count = 0;
    int                         fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = q_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fails++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // Sum of two non-negative singles, round to nearest even, overflow to +inf.
    function automatic logic [spr_pkg::DIST_W-1:0] add_dist(input logic [30:0] a,
                                                            input logic [31:0] b);
        int          ea, eb, eh, d;
        logic [23:0] ma, mb, mh, ml;
        logic [63:0] big, sml, s;
        logic [24:0] m;
        logic [29:0] rem;
        if (a[30:23] == 8'hff)
            return spr_pkg::PLUS_INF;
        ea = int'(a[30:23]);
        eb = int'(b[30:23]);
        ma = {ea != 0, a[22:0]};
        mb = {eb != 0, b[22:0]};
        if (ea == 0) ea = 1;
        if (eb == 0) eb = 1;
        if (ea >= eb) begin
            eh = ea; mh = ma; ml = mb; d = ea - eb;
        end else begin
            eh = eb; mh = mb; ml = ma; d = eb - ea;
        end
        big = {40'b0, mh} << 30;
        sml = {40'b0, ml} << 30;
        if (d >= 64) begin
            s = big | 64'(ml != 0);
        end else begin
            s = big + (sml >> d);
            if ((sml & ((64'd1 << d) - 64'd1)) != 0)
                s = s | 64'd1;
        end
        if (s[54]) begin
            s = (s >> 1) | 64'(s[0]);
            eh++;
        end
        m   = {1'b0, s[53:30]};
        rem = s[29:0];
        if (rem > 30'h2000_0000 || (rem == 30'h2000_0000 && m[0]))
            m = m + 25'd1;
        if (m[24]) begin
            m = m >> 1;
            eh++;
        end
        if (eh >= 255)
            return spr_pkg::PLUS_INF;
        if (!m[23])
            return {8'h00, m[22:0]};
        return {eh[7:0], m[22:0]};
    endfunction

    function automatic spr_pkg::t_out predict_result(input spr_pkg::t_in it);
        spr_pkg::t_out              r;
        logic [spr_pkg::DIST_W-1:0] cand;
        r = '0;
        case (spr_pkg::t_kind'(it.kind))
            spr_pkg::K_SET_ZERO: begin
                dist_mem[it.to_vertex] = '0;
            end
            spr_pkg::K_RELAX: begin
                r.distance_value = dist_mem[it.to_vertex];
                if (it.weight_bits[31] || it.weight_bits[30:23] == 8'hff) begin
                    r.bad_weight = 1'b1;
                end else if (it.edge_admitted) begin
                    cand = add_dist(dist_mem[it.from_vertex], it.weight_bits);
                    if (cand < r.distance_value) begin
                        dist_mem[it.to_vertex] = cand;
                        r.distance_value = cand;
                        r.decreased = 1'b1;
                        round_flag = 1'b1;
                    end
                end
            end
            spr_pkg::K_READ: begin
                r.distance_value = dist_mem[it.to_vertex];
            end
            default: begin
                r.round_changed = round_flag;
                round_flag = 1'b0;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        spr_pkg::t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < spr_pkg::NUM_VERTICES; i++)
                dist_mem[i] = spr_pkg::PLUS_INF;
            round_flag = 1'b0;
            q_wr       = '0;
            q_rd       = '0;
            q_count    = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (q_count == QDEPTH) begin
                    report_mismatch("expected results overflow", 32'(q_count),
                                    32'(QDEPTH));
                end else begin
                    exp_q[q_wr] = predict_result(i_in_data);
                    q_wr        = q_wr + 1'b1;
                    q_count++;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (q_count == 0) begin
                    report_mismatch("unexpected result", 32'(i_out_data), 32'h0);
                end else begin
                    want = exp_q[q_rd];
                    q_rd = q_rd + 1'b1;
                    q_count--;
                    if (i_out_data.decreased !== want.decreased)
                        report_mismatch("decreased", 32'(i_out_data.decreased),
                                        32'(want.decreased));
                    if (i_out_data.distance_value !== want.distance_value)
                        report_mismatch("distance_value",
                                        32'(i_out_data.distance_value),
                                        32'(want.distance_value));
                    if (i_out_data.round_changed !== want.round_changed)
                        report_mismatch("round_changed",
                                        32'(i_out_data.round_changed),
                                        32'(want.round_changed));
                    if (i_out_data.bad_weight !== want.bad_weight)
                        report_mismatch("bad_weight", 32'(i_out_data.bad_weight),
                                        32'(want.bad_weight));
                end
            end
        end
    end

endmodule

@@ test/shortest_path_edge_relaxer_tb.sv @@
// ----------------------------------------------------------------------------
// shortest_path_edge_relaxer_tb
// Drives set, relax, read and end-round items into the edge relaxer under
// several idling mixes and a long output hold; the checker judges results.
// ----------------------------------------------------------------------------
module shortest_path_edge_relaxer_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 300;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_stall;
    spr_pkg::t_in  in_data;
    logic          out_valid;
    logic          out_stall;
    spr_pkg::t_out out_data;
    int            fail_count;
    int            pending;
    int            tx_idle;
    int            rx_idle;
    logic          hold_req;
    int            cycle_count = 0;
    int            items_sent;

    shortest_path_edge_relaxer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    shortest_path_edge_relaxer_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls, or one long hold counted out here.
    initial begin
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_left = HOLD_LEN;
            end
            hold_seen = hold_req;
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle);
            end
        end
    end

    // Valid stays high after a transfer; the next call either replaces the
    // payload or drops valid, so each falling edge sees one update at most.
    task automatic send_item(input spr_pkg::t_in it);
        while ($urandom_range(99) < tx_idle) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic spr_pkg::t_in make_item(input spr_pkg::t_kind k, input int from_v,
                                               input int to_v, input logic [31:0] w,
                                               input logic adm);
        spr_pkg::t_in it;
        it.kind          = k;
        it.from_vertex   = from_v[spr_pkg::ADDR_W-1:0];
        it.to_vertex     = to_v[spr_pkg::ADDR_W-1:0];
        it.weight_bits   = w;
        it.edge_admitted = adm;
        return it;
    endfunction

    // Mostly relaxations over a small vertex window so that paths build up.
    function automatic spr_pkg::t_in random_item();
        spr_pkg::t_in it;
        int           sel;
        logic [31:0]  w;
        sel = int'($urandom_range(99));
        it = '0;
        if ($urandom_range(9) == 0) begin
            it.from_vertex = spr_pkg::ADDR_W'($urandom);
            it.to_vertex   = spr_pkg::ADDR_W'($urandom);
        end else begin
            it.from_vertex = spr_pkg::ADDR_W'($urandom_range(31));
            it.to_vertex   = spr_pkg::ADDR_W'($urandom_range(31));
        end
        if ($urandom_range(9) < 2)
            w = $urandom;
        else
            w = {1'b0, 8'($urandom_range(140, 110)), 23'($urandom)};
        it.weight_bits   = w;
        it.edge_admitted = ($urandom_range(9) != 0);
        if (sel < 8)       it.kind = spr_pkg::K_SET_ZERO;
        else if (sel < 78) it.kind = spr_pkg::K_RELAX;
        else if (sel < 90) it.kind = spr_pkg::K_READ;
        else               it.kind = spr_pkg::K_END_ROUND;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        in_valid   = 1'b0;
        in_data    = '0;
        i_rst_n    = 1'b0;
        tx_idle    = 0;
        rx_idle    = 0;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items: extremes, bad weights, overflow, subnormals.
        send_item(make_item(spr_pkg::K_END_ROUND, 0, 0, 32'h0, 1'b0));
        send_item(make_item(spr_pkg::K_READ, 0, 4095, 32'h0, 1'b0));
        send_item(make_item(spr_pkg::K_SET_ZERO, 4095, 0, 32'hffff_ffff, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 0, 1, 32'h3f80_0000, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 0, 1, 32'h3f80_0000, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 0, 2, 32'h0000_0000, 1'b0));
        send_item(make_item(spr_pkg::K_RELAX, 0, 2, 32'h8000_0000, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 0, 2, 32'hbf80_0000, 1'b0));
        send_item(make_item(spr_pkg::K_RELAX, 0, 2, 32'h7f80_0000, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 0, 2, 32'h7fc0_0001, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 0, 2, 32'hff80_0000, 1'b1));
        send_item(make_item(spr_pkg::K_END_ROUND, 0, 0, 32'h0, 1'b0));
        send_item(make_item(spr_pkg::K_RELAX, 0, 3, 32'h7f7f_ffff, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 3, 4, 32'h7f7f_ffff, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 0, 5, 32'h0000_0001, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 5, 6, 32'h007f_ffff, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 0, 4095, 32'h0000_0000, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 4095, 4095, 32'h7f7f_ffff, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 4095, 0, 32'h3f80_0000, 1'b1));
        send_item(make_item(spr_pkg::K_RELAX, 2048, 7, 32'h4000_0000, 1'b1));
        send_item(make_item(spr_pkg::K_READ, 0, 4095, 32'h0, 1'b0));
        send_item(make_item(spr_pkg::K_END_ROUND, 4095, 4095, 32'hffff_ffff, 1'b1));
        send_item(make_item(spr_pkg::K_END_ROUND, 0, 0, 32'h0, 1'b0));

        tx_idle = 20;
        rx_idle = 69;
        repeat (360) send_item(random_item());

        // Long output hold while items keep coming, then drain completely.
        tx_idle  = 0;
        hold_req = 1'b1;
        repeat (40) send_item(random_item());
        in_valid <= 1'b0;
        wait_drained();

        tx_idle = 69;
        rx_idle = 20;
        repeat (340) send_item(random_item());
        tx_idle = 0;
        rx_idle = 0;
        repeat (340) send_item(random_item());
        in_valid <= 1'b0;

        wait_drained();
        repeat (20) @(negedge i_clk);
        $display("Run covered %0d items: set, relax, read and round end under",
                 items_sent);
        $display("three idling mixes, a long output hold and a full drain.");
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
